/* rtl/bit_scatter_xor_scrambler_defines.svh */
// assertion macros for the bit scatter xor scrambler
`ifndef BIT_SCATTER_XOR_SCRAMBLER_DEFINES_SVH
`define BIT_SCATTER_XOR_SCRAMBLER_DEFINES_SVH

// same-cycle implication, checked while not in reset
`define BSXS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsxs assertion failed");

// next-cycle implication, checked while not in reset
`define BSXS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsxs assertion failed");

`endif

/* rtl/bsxs_pkg.sv */
// types, constants and transform functions of the bit scatter xor scrambler
package bsxs_pkg;

   localparam int BlkBytes = 10;
   localparam int BlkBits  = 8 * BlkBytes;

   localparam logic [1:0] OpForward  = 2'd0;
   localparam logic [1:0] OpReverse  = 2'd1;
   localparam logic [1:0] OpVerify   = 2'd2;
   localparam logic [1:0] OpGenerate = 2'd3;

   localparam logic [0:0] CsrSecurityKey   = 1'd0;
   localparam logic [0:0] CsrHourTolerance = 1'd1;

   localparam logic [47:0] SecurityKeyReset   = 48'h4142_4344_4546;
   localparam logic [7:0]  HourToleranceReset = 8'h1A;
   localparam logic [31:0] HourMask           = 32'hFFFF_FF00;

   localparam logic [7:0] SteerMask [BlkBytes] =
      '{8'h46, 8'h58, 8'h9A, 8'h32, 8'h70, 8'h87, 8'h23, 8'h99, 8'h85, 8'h64};
   localparam int LinkIdx [BlkBytes] = '{6, 8, 1, 2, 0, 7, 3, 9, 5, 4};

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] block_hi;
      logic [63:0] block_lo;
      logic [31:0] run_hours;
   } req_type;

   typedef struct packed {
      logic [15:0] result_hi;
      logic [63:0] result_lo;
      logic        passed;
   } rsp_type;

   // bit position in the scattered block of input bit k (msb first)
   function automatic logic [6:0] scat_pos(input int k);
      int   fw;
      int   bw;
      logic up;
      logic [6:0] pos;
      fw  = 0;
      bw  = 0;
      pos = '0;
      for (int i = 0; i < BlkBytes; i++) begin
         for (int p = 0; p < 8; p++) begin
            up = SteerMask[i][7 - p];
            if (i * 8 + p == k) begin
               if (!up) begin
                  pos = 7'((BlkBytes - 1 - (fw >> 3)) * 8 + (7 - (fw & 7)));
               end else begin
                  pos = 7'((bw >> 3) * 8 + (bw & 7));
               end
            end
            if (up) begin
               bw++;
            end else begin
               fw++;
            end
         end
      end
      return pos;
   endfunction

   function automatic logic [BlkBits-1:0] fwd_xform(input logic [BlkBits-1:0] src);
      logic [BlkBits-1:0] sc;
      logic [BlkBits-1:0] dst;
      logic [7:0]         w [BlkBytes];
      sc  = '0;
      dst = '0;
      for (int k = 0; k < BlkBits; k++) begin
         sc[scat_pos(k)] = src[BlkBits - 1 - k];
      end
      for (int i = 0; i < BlkBytes; i++) begin
         w[i] = sc[BlkBits - 1 - 8 * i -: 8];
      end
      for (int i = 0; i < BlkBytes; i++) begin
         w[i] = w[i] ^ w[LinkIdx[i]];
      end
      for (int i = 0; i < BlkBytes; i++) begin
         dst[BlkBits - 1 - 8 * LinkIdx[BlkBytes - 1 - i] -: 8] = w[i];
      end
      return dst;
   endfunction

   function automatic logic [BlkBits-1:0] rev_xform(input logic [BlkBits-1:0] src);
      logic [BlkBits-1:0] sc;
      logic [BlkBits-1:0] dst;
      logic [7:0]         w [BlkBytes];
      dst = '0;
      for (int i = 0; i < BlkBytes; i++) begin
         w[i] = src[BlkBits - 1 - 8 * LinkIdx[BlkBytes - 1 - i] -: 8];
      end
      for (int i = BlkBytes - 1; i >= 0; i--) begin
         w[i] = w[i] ^ w[LinkIdx[i]];
      end
      for (int i = 0; i < BlkBytes; i++) begin
         sc[BlkBits - 1 - 8 * i -: 8] = w[i];
      end
      for (int k = 0; k < BlkBits; k++) begin
         dst[BlkBits - 1 - k] = sc[scat_pos(k)];
      end
      return dst;
   endfunction

endpackage

/* rtl/bit_scatter_xor_scrambler.sv */
// top level of the bit scatter xor scrambler
//
// req channel: one 80-bit block per transaction with an operation code and an
// hour meter; rsp channel: the transformed block and a passed flag. both use
// valid/stall; the receiver drives stall.
// csr channel: index 0 writes the 48-bit security key, index 1 the 8-bit hour
// tolerance from the low data bits. csr_ready is always high; write only idle.
// path: a request is taken into the input register, then into the result
// register with the bit wiring, xor chain and compares in between; rsp_valid
// rises when the result register is loaded.
// throughput: one transaction per cycle while rsp is not stalled, set by the
// single-pass logic between the two registers.
// rsp stall: the result register holds; the input register still takes one
// more transaction, then req_stall rises until the result is taken.
// reset: both stages empty, key and tolerance back to their defaults.
module bit_scatter_xor_scrambler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bsxs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bsxs_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [0:0]        csr_index,
   input  logic [47:0]       csr_data
);
   import bsxs_pkg::*;

   req_type       req_ff;
   logic          req_valid_ff;
   logic          req_valid_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [47:0]   key_ff;
   logic [7:0]    tol_ff;
   logic          out_en;
   logic          move;
   logic          req_acc;
   logic [BlkBits-1:0] blk;
   logic [BlkBits-1:0] fwd;
   logic [BlkBits-1:0] rev_src;
   logic [BlkBits-1:0] rev;
   logic [BlkBits-1:0] res;
   logic [31:0]   em;
   logic [31:0]   rm;
   logic [31:0]   diff;
   logic          key_ok;
   logic          hour_ok;

   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign move      = req_valid_ff && out_en;
   assign req_stall = req_valid_ff && !out_en;
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign req_valid_in = req_acc || (req_valid_ff && !move);
   assign rsp_valid_in = move || (rsp_valid_ff && !out_en);

   always_comb begin
      blk     = {req_ff.block_hi, req_ff.block_lo};
      fwd     = fwd_xform(blk);
      rev_src = (req_ff.operation == OpGenerate) ? {key_ff, req_ff.run_hours} : blk;
      rev     = rev_xform(rev_src);
      em      = req_ff.run_hours & HourMask;
      rm      = fwd[31:0] & HourMask;
      diff    = em - rm;
      key_ok  = (fwd[BlkBits-1 -: 48] == key_ff);
      hour_ok = (em >= rm) && (diff < {24'd0, tol_ff});
      case (req_ff.operation)
         OpForward: begin
            res           = fwd;
            rsp_in.passed = 1'b0;
         end
         OpReverse: begin
            res           = rev;
            rsp_in.passed = 1'b0;
         end
         OpVerify: begin
            res           = fwd;
            rsp_in.passed = key_ok && hour_ok;
         end
         OpGenerate: begin
            res           = rev;
            rsp_in.passed = 1'b1;
         end
         default: begin
            res           = fwd;
            rsp_in.passed = 1'b0;
         end
      endcase
      rsp_in.result_hi = res[BlkBits-1 -: 16];
      rsp_in.result_lo = res[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         key_ff       <= SecurityKeyReset;
         tol_ff       <= HourToleranceReset;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrSecurityKey:   key_ff <= csr_data;
               CsrHourTolerance: tol_ff <= csr_data[7:0];
               default:          key_ff <= key_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         req_ff <= req_data;
      end
      if (move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/bsxs_checker.sv */
// port-level checks of the bit scatter xor scrambler and their bind
`include "bit_scatter_xor_scrambler_defines.svh"

module bsxs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input bsxs_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bsxs_pkg::rsp_type rsp_data,
   input logic              csr_valid,
   input logic              csr_ready
);
   import bsxs_pkg::*;

   // stalled result holds
   `BSXS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   // stalled request holds
   `BSXS_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_data))
   // reset empties the result stage
   `BSXS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   // input only stalls when the result stage is blocked
   `BSXS_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   // csr channel never pushes back
   `BSXS_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind bit_scatter_xor_scrambler bsxs_checker u_bsxs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);
